[rtl/core/prarq_pkg.sv]
// ----------------------------------------------------------------------------
// prarq_pkg
// Shared types and constants for the partial-reliability ARQ sender.
// ----------------------------------------------------------------------------
package prarq_pkg;

  localparam int WINDOW_SIZE = 10;
  localparam int SLOT_W      = $clog2(WINDOW_SIZE);
  localparam int LOSS_W      = 5;
  localparam int LOSS_PCT_W  = 7;
  localparam int ATTEMPT_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CMP_W       = 11;
  localparam int PERCENT     = 100;

  localparam logic [LOSS_PCT_W-1:0] LOSS_PCT_RESET = LOSS_PCT_W'(10);
  localparam logic [ATTEMPT_W-1:0]  ATTEMPT_RESET  = ATTEMPT_W'(20);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALLOWED_LOSS = 1'b0,
    REG_MAX_ATTEMPTS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } operation_t;

  typedef enum logic [2:0] {
    ACT_IGNORED    = 3'd0,
    ACT_TRANSMIT   = 3'd1,
    ACT_RETRANSMIT = 3'd2,
    ACT_DELIVERED  = 3'd3,
    ACT_LOSS_OK    = 3'd4,
    ACT_FAILED     = 3'd5
  } action_t;

  typedef struct packed {
    action_t           action;
    logic              seq_bit;
    logic [LOSS_W-1:0] losses;
  } result_t;

endpackage

[rtl/core/partial_reliability_arq_sender.sv]
// ----------------------------------------------------------------------------
// partial_reliability_arq_sender
// Sender side of an alternating-bit stop-and-wait ARQ that tolerates a bounded
// share of lost packets in a sliding window of outcomes.
//
// Channel  Handshake          Payload
// in       in_valid/in_stall  operation, ack_flag, ack_seq
// out      out_valid/out_stall action, seq_bit, losses_in_window
// cfg      cfg_write          cfg_index, cfg_data
//
// Each event is evaluated in the cycle it is accepted and its result appears
// in the output register on the next cycle unless the output is stalled. While
// in_stall is low one event per cycle is taken. The loss count and its compare
// are the longest path in that cycle. A skid register behind the output register
// holds one more word while the output is stalled; in_stall rises when it is full.
// Synchronous reset clears the protocol state and restores register defaults.
// ----------------------------------------------------------------------------
module partial_reliability_arq_sender (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [prarq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [prarq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             operation,
  input  logic                                   ack_flag,
  input  logic                                   ack_seq,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output prarq_pkg::action_t                     action,
  output logic                                   seq_bit,
  output logic [prarq_pkg::LOSS_W-1:0]           losses_in_window
);
  import prarq_pkg::*;

  logic [LOSS_PCT_W-1:0]  allowed_loss_percent;
  logic [ATTEMPT_W-1:0]   max_attempts;

  logic [WINDOW_SIZE-1:0] outcome_window;
  logic [WINDOW_SIZE-1:0] outcome_window_next;
  logic [SLOT_W-1:0]      slot_pointer;
  logic [SLOT_W-1:0]      slot_pointer_next;
  logic [ATTEMPT_W-1:0]   attempt_count;
  logic [ATTEMPT_W-1:0]   attempt_count_next;
  logic                   sequence_bit;
  logic                   sequence_bit_next;
  logic                   awaiting_ack;
  logic                   awaiting_ack_next;

  logic [WINDOW_SIZE-1:0] timeout_window;
  logic [LOSS_W-1:0]      timeout_lost;
  logic [LOSS_W-1:0]      lost_next;
  logic [SLOT_W-1:0]      slot_advanced;
  logic                   loss_ok;
  action_t                act;
  result_t                res;

  result_t                out_reg;
  result_t                skid;
  logic                   skid_valid;
  logic                   accept_in;
  logic                   out_free;

  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_loss_percent <= LOSS_PCT_RESET;
      max_attempts         <= ATTEMPT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALLOWED_LOSS: allowed_loss_percent <= cfg_data[LOSS_PCT_W-1:0];
        REG_MAX_ATTEMPTS: max_attempts         <= cfg_data[ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    timeout_window = outcome_window;
    timeout_window[slot_pointer] = 1'b0;
    timeout_lost = '0;
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      timeout_lost = timeout_lost + LOSS_W'(!timeout_window[k]);
    end
    loss_ok = (CMP_W'(timeout_lost) * CMP_W'(PERCENT))
              <= (CMP_W'(allowed_loss_percent) * CMP_W'(WINDOW_SIZE));
    slot_advanced = (slot_pointer == SLOT_W'(WINDOW_SIZE - 1))
                    ? '0 : slot_pointer + SLOT_W'(1);
  end

  always_comb begin
    outcome_window_next = outcome_window;
    slot_pointer_next   = slot_pointer;
    attempt_count_next  = attempt_count;
    sequence_bit_next   = sequence_bit;
    awaiting_ack_next   = awaiting_ack;
    act                 = ACT_IGNORED;
    case (operation_t'(operation))
      OP_SEND: begin
        if (!awaiting_ack) begin
          awaiting_ack_next  = 1'b1;
          attempt_count_next = ATTEMPT_W'(1);
          act                = ACT_TRANSMIT;
        end
      end
      OP_ACK: begin
        if (awaiting_ack && ack_flag && (ack_seq == sequence_bit)) begin
          outcome_window_next[slot_pointer] = 1'b1;
          slot_pointer_next = slot_advanced;
          sequence_bit_next = !sequence_bit;
          awaiting_ack_next = 1'b0;
          act               = ACT_DELIVERED;
        end
      end
      OP_TIMEOUT: begin
        if (awaiting_ack) begin
          outcome_window_next = timeout_window;
          if (loss_ok) begin
            slot_pointer_next = slot_advanced;
            awaiting_ack_next = 1'b0;
            act               = ACT_LOSS_OK;
          end else if (attempt_count < max_attempts) begin
            attempt_count_next = attempt_count + ATTEMPT_W'(1);
            act                = ACT_RETRANSMIT;
          end else begin
            awaiting_ack_next = 1'b0;
            act               = ACT_FAILED;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    lost_next = '0;
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      lost_next = lost_next + LOSS_W'(!outcome_window_next[k]);
    end
    res.action  = act;
    res.seq_bit = sequence_bit;
    res.losses  = lost_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outcome_window <= '1;
      slot_pointer   <= '0;
      attempt_count  <= '0;
      sequence_bit   <= 1'b0;
      awaiting_ack   <= 1'b0;
    end else if (accept_in) begin
      outcome_window <= outcome_window_next;
      slot_pointer   <= slot_pointer_next;
      attempt_count  <= attempt_count_next;
      sequence_bit   <= sequence_bit_next;
      awaiting_ack   <= awaiting_ack_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept_in) begin
        out_reg <= res;
      end
    end else if (accept_in) begin
      skid <= res;
    end
  end

  assign action           = out_reg.action;
  assign seq_bit          = out_reg.seq_bit;
  assign losses_in_window = out_reg.losses;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the output register is empty");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    slot_pointer < SLOT_W'(WINDOW_SIZE))
    else $error("slot pointer left the window");

  a_attempts_while_busy: assert property (@(posedge clk) disable iff (rst)
    awaiting_ack |-> (attempt_count != '0))
    else $error("packet in flight with no transmission counted");

  a_losses_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (losses_in_window <= LOSS_W'(WINDOW_SIZE)))
    else $error("loss count exceeds window size");
`endif

endmodule

[tb/tb_partial_reliability_arq_sender.sv]
// ----------------------------------------------------------------------------
// tb_partial_reliability_arq_sender
// Self-checking bench for the partial-reliability ARQ sender. A short table of
// directed events runs first. Random event streams follow, with mostly
// well-formed send/ack/timeout exchanges under several loss and attempt
// settings. Every event word is predicted in the bench, and each output word
// is compared with the oldest prediction; both sides stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_partial_reliability_arq_sender;
  timeunit 1ns;
  timeprecision 1ps;
  import prarq_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int IDLE_LIMIT      = 4000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 120;
  localparam int REPORT_CAP      = 40;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    operation_t            op;
    logic                  flag;
    logic                  aseq;
    bit                    typed;
    result_t               res;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  operation_t            operation;
  logic                  ack_flag;
  logic                  ack_seq;
  logic                  out_valid;
  logic                  out_stall;
  action_t               action;
  logic                  seq_bit;
  logic [LOSS_W-1:0]     losses_in_window;

  logic [WINDOW_SIZE-1:0] outcome_bits;
  int unsigned            slot_idx;
  logic [ATTEMPT_W-1:0]   tries;
  logic                   cur_seq;
  logic                   in_flight;
  logic [LOSS_PCT_W-1:0]  loss_pct_cfg;
  logic [ATTEMPT_W-1:0]   attempt_cfg;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  bit        typed_valid;
  result_t   typed_res;
  bit        tx_quiet;
  bit        rx_quiet;
  int        useful_words;
  int        mismatches;
  int        idle_cycles;

  partial_reliability_arq_sender u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .ack_flag         (ack_flag),
    .ack_seq          (ack_seq),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .action           (action),
    .seq_bit          (seq_bit),
    .losses_in_window (losses_in_window)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t sender_event(operation_t op, logic flag, logic aseq);
    result_t     r;
    int unsigned lost;
    r.action  = ACT_IGNORED;
    r.seq_bit = cur_seq;
    case (op)
      OP_SEND: begin
        if (!in_flight) begin
          in_flight = 1'b1;
          tries     = ATTEMPT_W'(1);
          r.action  = ACT_TRANSMIT;
        end
      end
      OP_ACK: begin
        if (in_flight && flag && aseq == cur_seq) begin
          outcome_bits[slot_idx] = 1'b1;
          slot_idx  = (slot_idx + 1) % WINDOW_SIZE;
          cur_seq   = ~cur_seq;
          in_flight = 1'b0;
          r.action  = ACT_DELIVERED;
        end
      end
      OP_TIMEOUT: begin
        if (in_flight) begin
          outcome_bits[slot_idx] = 1'b0;
          lost = $countones(~outcome_bits);
          if (lost * PERCENT <= int'(loss_pct_cfg) * WINDOW_SIZE) begin
            slot_idx  = (slot_idx + 1) % WINDOW_SIZE;
            in_flight = 1'b0;
            r.action  = ACT_LOSS_OK;
          end else if (tries < attempt_cfg) begin
            tries    = tries + 1'b1;
            r.action = ACT_RETRANSMIT;
          end else begin
            in_flight = 1'b0;
            r.action  = ACT_FAILED;
          end
        end
      end
      default: begin
      end
    endcase
    r.losses = LOSS_W'($countones(~outcome_bits));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    bit      busy;
    if (rst) begin
      loss_pct_cfg = LOSS_PCT_RESET;
      attempt_cfg  = ATTEMPT_RESET;
      outcome_bits = '1;
      slot_idx     = 0;
      tries        = '0;
      cur_seq      = 1'b0;
      in_flight    = 1'b0;
      idle_cycles  = 0;
    end else begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested word, action", int'(action), -1);
        end else begin
          want = pending_results.pop_front();
          if (action != want.action)
            report_mismatch("action", int'(action), int'(want.action));
          if (seq_bit != want.seq_bit)
            report_mismatch("seq_bit", int'(seq_bit), int'(want.seq_bit));
          if (losses_in_window != want.losses)
            report_mismatch("losses_in_window", int'(losses_in_window), int'(want.losses));
        end
      end
      if (cfg_write) begin
        busy = 1'b1;
        if (cfg_index == REG_ALLOWED_LOSS) loss_pct_cfg = cfg_data[LOSS_PCT_W-1:0];
        else attempt_cfg = cfg_data[ATTEMPT_W-1:0];
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        want = sender_event(operation, ack_flag, ack_seq);
        if (want.action != ACT_IGNORED) useful_words++;
        if (typed_valid) want = typed_res;
        pending_results.push_back(want);
      end
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb_partial_reliability_arq_sender: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    int n;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_stall || rx_quiet) begin
        out_stall = 1'b0;
        hold      = $urandom_range(0, 5);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall = 1'b1;
          hold      = n - 1;
        end
      end
    end
  end

  function automatic void row_word(operation_t op, logic flag, logic aseq);
    stim_row_t row;
    row.kind  = ROW_WORD;
    row.op    = op;
    row.flag  = flag;
    row.aseq  = aseq;
    row.typed = 1'b0;
    row.res   = '0;
    row.idx   = REG_ALLOWED_LOSS;
    row.data  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_check(operation_t op, logic flag, logic aseq, action_t act,
                                    logic sb, int losses);
    stim_row_t row;
    row.kind           = ROW_WORD;
    row.op             = op;
    row.flag           = flag;
    row.aseq           = aseq;
    row.typed          = 1'b1;
    row.res.action     = act;
    row.res.seq_bit    = sb;
    row.res.losses     = LOSS_W'(losses);
    row.idx            = REG_ALLOWED_LOSS;
    row.data           = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_REG;
    row.op    = OP_NONE;
    row.flag  = 1'b0;
    row.aseq  = 1'b0;
    row.typed = 1'b0;
    row.res   = '0;
    row.idx   = idx;
    row.data  = data;
    directed_rows.push_back(row);
  endfunction

  task automatic send_word(operation_t op, logic flag, logic aseq, bit typed, result_t res);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation   = op;
    ack_flag    = flag;
    ack_seq     = aseq;
    typed_valid = typed;
    typed_res   = res;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin : stimulus
    int                    target;
    int                    r;
    int                    tmo_pct;
    operation_t            op;
    logic                  flag;
    logic                  aseq;
    logic [CFG_DATA_W-1:0] loss_data;
    logic [CFG_DATA_W-1:0] tries_data;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_ALLOWED_LOSS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    operation    = OP_SEND;
    ack_flag     = 1'b0;
    ack_seq      = 1'b0;
    typed_valid  = 1'b0;
    typed_res    = '0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    useful_words = 0;
    mismatches   = 0;

    // Idle events, a full exchange, then one accepted loss and a retransmit.
    row_check(OP_ACK, 1'b1, 1'b0, ACT_IGNORED, 1'b0, 0);
    row_check(OP_TIMEOUT, 1'b1, 1'b1, ACT_IGNORED, 1'b0, 0);
    row_check(OP_NONE, 1'b1, 1'b1, ACT_IGNORED, 1'b0, 0);
    row_check(OP_SEND, 1'b0, 1'b0, ACT_TRANSMIT, 1'b0, 0);
    row_check(OP_SEND, 1'b1, 1'b1, ACT_IGNORED, 1'b0, 0);
    row_check(OP_ACK, 1'b0, 1'b0, ACT_IGNORED, 1'b0, 0);
    row_check(OP_ACK, 1'b1, 1'b1, ACT_IGNORED, 1'b0, 0);
    row_check(OP_ACK, 1'b1, 1'b0, ACT_DELIVERED, 1'b0, 0);
    row_word(OP_SEND, 1'b0, 1'b1);
    row_word(OP_TIMEOUT, 1'b0, 1'b0);
    row_word(OP_SEND, 1'b1, 1'b0);
    row_word(OP_TIMEOUT, 1'b1, 1'b0);
    row_word(OP_ACK, 1'b1, 1'b1);
    // No loss allowed and no attempts: the first timeout fails.
    row_reg(REG_ALLOWED_LOSS, 8'd0);
    row_reg(REG_MAX_ATTEMPTS, 8'd0);
    row_word(OP_SEND, 1'b0, 1'b0);
    row_check(OP_TIMEOUT, 1'b0, 1'b0, ACT_FAILED, 1'b0, 2);
    row_word(OP_SEND, 1'b0, 1'b0);
    row_check(OP_TIMEOUT, 1'b0, 1'b0, ACT_FAILED, 1'b0, 2);
    // A percentage above 100 accepts every loss.
    row_reg(REG_ALLOWED_LOSS, 8'hFF);
    row_reg(REG_MAX_ATTEMPTS, 8'hFF);
    row_word(OP_SEND, 1'b1, 1'b1);
    row_check(OP_TIMEOUT, 1'b1, 1'b1, ACT_LOSS_OK, 1'b0, 2);
    row_reg(REG_ALLOWED_LOSS, 8'd100);
    row_reg(REG_MAX_ATTEMPTS, 8'd1);
    row_word(OP_SEND, 1'b0, 1'b0);
    row_word(OP_TIMEOUT, 1'b0, 1'b0);
    row_reg(REG_ALLOWED_LOSS, 8'd0);
    row_word(OP_SEND, 1'b0, 1'b0);
    row_check(OP_TIMEOUT, 1'b0, 1'b0, ACT_FAILED, 1'b0, 4);
    row_reg(REG_MAX_ATTEMPTS, 8'd2);
    row_word(OP_SEND, 1'b0, 1'b0);
    row_word(OP_TIMEOUT, 1'b0, 1'b0);
    row_check(OP_TIMEOUT, 1'b0, 1'b0, ACT_FAILED, 1'b0, 4);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].op, directed_rows[i].flag, directed_rows[i].aseq,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          loss_data  = 8'd10;
          tries_data = 8'd20;
        end
        1: begin
          loss_data  = 8'd0;
          tries_data = 8'd1;
        end
        2: begin
          loss_data  = 8'd100;
          tries_data = 8'd255;
        end
        3: begin
          loss_data  = 8'hFF;
          tries_data = 8'd0;
        end
        4: begin
          loss_data  = 8'd0;
          tries_data = 8'd255;
        end
        5: begin
          loss_data  = 8'd50;
          tries_data = 8'd2;
        end
        6: begin
          loss_data  = CFG_DATA_W'($urandom_range(0, 30));
          tries_data = 8'd0;
        end
        default: begin
          loss_data  = CFG_DATA_W'($urandom_range(0, 255));
          tries_data = CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_ALLOWED_LOSS, loss_data);
      write_reg(REG_MAX_ATTEMPTS, tries_data);
      tmo_pct  = $urandom_range(15, 90);
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2 || ph == 5);
      target   = useful_words + WORDS_PER_PHASE;
      while (useful_words < target) begin
        r    = $urandom_range(0, 99);
        op   = operation_t'($urandom_range(0, 3));
        flag = 1'($urandom);
        aseq = 1'($urandom);
        if (r >= 10) begin
          if (!in_flight) begin
            op = OP_SEND;
          end else begin
            r = $urandom_range(0, 99);
            if (r < tmo_pct) begin
              op = OP_TIMEOUT;
            end else begin
              op = OP_ACK;
              if (r < tmo_pct + (100 - tmo_pct) * 4 / 5) begin
                flag = 1'b1;
                aseq = cur_seq;
              end
            end
          end
        end
        send_word(op, flag, aseq, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_partial_reliability_arq_sender: PASS");
    end else begin
      $display("tb_partial_reliability_arq_sender: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/prarq_pkg.sv
rtl/core/partial_reliability_arq_sender.sv
tb/tb_partial_reliability_arq_sender.sv
